[rtl/tsp_pkg.sv]
// ----------------------------------------------------------------------------
// tsp_pkg
// Shared types and constants of the transport stream section packetizer.
// ----------------------------------------------------------------------------
package tsp_pkg;

    localparam int POS_W       = 8;   // packet position / repeat count width
    localparam int PID_W       = 13;
    localparam int CC_W        = 4;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] SYNC_BYTE    = 8'h47;
    localparam logic [7:0] PUSI_FLAG    = 8'h40;
    localparam logic [7:0] PAYLOAD_ONLY = 8'h10;
    localparam logic [7:0] STUFF_BYTE   = 8'hFF;
    localparam logic [7:0] POINTER_ZERO = 8'h00;

    // register indexes of the configuration port
    localparam logic REG_PID = 1'b0;

    // one classified input beat, handed from front to back
    typedef struct packed {
        logic             hdr;        // open a packet before the data byte
        logic             pusi;       // packet starts a section
        logic [CC_W-1:0]  cc;         // continuity count for the header
        logic [7:0]       data;
        logic             stuff;      // fill the packet after the data byte
        logic [POS_W-1:0] stuff_cnt;
    } t_cmd;

endpackage

[rtl/ts_section_packetizer_unit.sv]
// ----------------------------------------------------------------------------
// ts_section_packetizer_unit
// Cuts PSI section bytes into transport packets: 4-byte header, pointer
// field on the first packet of a section, 0xFF stuffing as one repeat beat.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  input     in         i_valid / o_ready    i_data_byte, i_last_of_section
//  output    out        o_valid / i_ready    o_out_byte, o_repeat_count,
//                                            o_last_of_item
//  config    in         psel/penable/pwrite  paddr, pwdata, prdata (PID register)
//
//  An input beat is taken in any cycle the command queue has room; the front
//  classifies it in that same cycle. The back emits one output beat per
//  cycle unless stalled or out of commands: 1 for a plain data byte, 5 or 6 when
//  it opens a packet (header and pointer field), plus 1 for a stuffing run, so
//  the output port sets the sustained rate. Each byte passes the queue, then the
//  output register. Synchronous active-low reset: empty queue, no packet open,
//  section start set, continuity count 0, PID register 0x1FFF. A stall on the
//  output holds the output register; the queue absorbs input beats until full.
// ----------------------------------------------------------------------------
module ts_section_packetizer_unit #(
    parameter int PACKET_BYTES = 188
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // section byte input
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_section,
    // transport byte output
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic [7:0]  o_repeat_count,
    output logic        o_last_of_item,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [tsp_pkg::PID_W-1:0] r_pid;

    logic          push;
    logic          pop;
    logic          q_full;
    logic          q_valid;
    tsp_pkg::t_cmd cmd;
    tsp_pkg::t_cmd head;

    // register index is paddr[2]; writes to any other index are dropped
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pid <= '1;
        end else if (psel && penable && pwrite && (paddr[2] == tsp_pkg::REG_PID)) begin
            r_pid <= pwdata[tsp_pkg::PID_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == tsp_pkg::REG_PID) begin
            prdata = {{(32 - tsp_pkg::PID_W){1'b0}}, r_pid};
        end else begin
            prdata = '0;
        end
    end

    // front: position tracking and classification
    tsp_front #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_data_byte       (i_data_byte),
        .i_last_of_section (i_last_of_section),
        .i_full            (q_full),
        .o_push            (push),
        .o_cmd             (cmd)
    );

    tsp_cmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_valid (q_valid)
    );

    // back: beat sequencer with output register
    tsp_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head),
        .i_head_valid   (q_valid),
        .o_pop          (pop),
        .i_pid          (r_pid),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_out_byte     (o_out_byte),
        .o_repeat_count (o_repeat_count),
        .o_last_of_item (o_last_of_item)
    );

endmodule

[rtl/tsp_front.sv]
// ----------------------------------------------------------------------------
// tsp_front
// Accepts section bytes, tracks packet position, section start and the
// continuity count, and emits one command per byte.
// ----------------------------------------------------------------------------
module tsp_front #(
    parameter int PACKET_BYTES = 188
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_of_section,
    input  logic          i_full,
    output logic          o_push,
    output tsp_pkg::t_cmd o_cmd
);

    localparam logic [tsp_pkg::POS_W-1:0] PKT_LEN = tsp_pkg::POS_W'(PACKET_BYTES);

    logic [tsp_pkg::POS_W-1:0] r_pos, n_pos;
    logic                      r_sec_start, n_sec_start;
    logic [tsp_pkg::CC_W-1:0]  r_cc, n_cc;

    logic                      open_pkt;
    logic [tsp_pkg::POS_W-1:0] pos_hdr;
    logic [tsp_pkg::POS_W-1:0] pos_inc;
    logic [tsp_pkg::POS_W-1:0] pos_after;

    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full;
    assign open_pkt = (r_pos == '0);

    always_comb begin
        if (open_pkt) begin
            pos_hdr = r_sec_start ? tsp_pkg::POS_W'(5) : tsp_pkg::POS_W'(4);
        end else begin
            pos_hdr = r_pos;
        end
        pos_inc   = pos_hdr + tsp_pkg::POS_W'(1);
        pos_after = (pos_inc >= PKT_LEN) ? '0 : pos_inc;

        o_cmd.hdr       = open_pkt;
        o_cmd.pusi      = r_sec_start;
        o_cmd.cc        = r_cc;
        o_cmd.data      = i_data_byte;
        o_cmd.stuff     = i_last_of_section && (pos_after != '0);
        o_cmd.stuff_cnt = PKT_LEN - pos_after;

        n_cc        = open_pkt ? r_cc + tsp_pkg::CC_W'(1) : r_cc;
        n_pos       = i_last_of_section ? '0 : pos_after;
        n_sec_start = i_last_of_section;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_sec_start <= 1'b1;
            r_cc        <= '0;
        end else if (o_push) begin
            r_pos       <= n_pos;
            r_sec_start <= n_sec_start;
            r_cc        <= n_cc;
        end
    end

endmodule

[rtl/tsp_cmd_queue.sv]
// ----------------------------------------------------------------------------
// tsp_cmd_queue
// Small command FIFO between front and back.
// ----------------------------------------------------------------------------
module tsp_cmd_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tsp_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output tsp_pkg::t_cmd o_head,
    output logic          o_full,
    output logic          o_valid
);

    localparam int PTR_W = $clog2(tsp_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(tsp_pkg::QUEUE_DEPTH + 1);

    tsp_pkg::t_cmd    r_mem [tsp_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(tsp_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[rtl/tsp_back.sv]
// ----------------------------------------------------------------------------
// tsp_back
// Expands each command into output beats: header, pointer field, data byte
// and stuffing run, one beat per unstalled cycle through an output register.
// ----------------------------------------------------------------------------
module tsp_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  tsp_pkg::t_cmd                  i_head,
    input  logic                           i_head_valid,
    output logic                           o_pop,
    input  logic [tsp_pkg::PID_W-1:0]      i_pid,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [7:0]                     o_out_byte,
    output logic [tsp_pkg::POS_W-1:0]      o_repeat_count,
    output logic                           o_last_of_item
);

    localparam logic [2:0] STEP_START  = 3'd0;
    localparam logic [2:0] STEP_SYNC   = 3'd1;
    localparam logic [2:0] STEP_PID_HI = 3'd2;
    localparam logic [2:0] STEP_PID_LO = 3'd3;
    localparam logic [2:0] STEP_CC     = 3'd4;
    localparam logic [2:0] STEP_PTR    = 3'd5;
    localparam logic [2:0] STEP_DATA   = 3'd6;
    localparam logic [2:0] STEP_STUFF  = 3'd7;

    logic [2:0]                r_step;
    logic [2:0]                cur_step, nxt_step;
    logic                      r_out_valid;
    logic [7:0]                r_out_byte, n_out_byte;
    logic [tsp_pkg::POS_W-1:0] r_rep, n_rep;
    logic                      r_last, n_last;
    logic                      advance;

    assign advance = i_head_valid && (!r_out_valid || i_ready);
    assign o_pop   = advance && n_last;

    always_comb begin
        if (r_step == STEP_START) begin
            cur_step = i_head.hdr ? STEP_SYNC : STEP_DATA;
        end else begin
            cur_step = r_step;
        end

        n_rep      = tsp_pkg::POS_W'(1);
        n_last     = 1'b0;
        n_out_byte = i_head.data;
        nxt_step   = STEP_START;
        unique case (cur_step)
            STEP_SYNC: begin
                n_out_byte = tsp_pkg::SYNC_BYTE;
                nxt_step   = STEP_PID_HI;
            end
            STEP_PID_HI: begin
                n_out_byte = (i_head.pusi ? tsp_pkg::PUSI_FLAG : 8'h00)
                           | {3'b000, i_pid[12:8]};
                nxt_step   = STEP_PID_LO;
            end
            STEP_PID_LO: begin
                n_out_byte = i_pid[7:0];
                nxt_step   = STEP_CC;
            end
            STEP_CC: begin
                n_out_byte = tsp_pkg::PAYLOAD_ONLY | {4'h0, i_head.cc};
                nxt_step   = i_head.pusi ? STEP_PTR : STEP_DATA;
            end
            STEP_PTR: begin
                n_out_byte = tsp_pkg::POINTER_ZERO;
                nxt_step   = STEP_DATA;
            end
            STEP_STUFF: begin
                n_out_byte = tsp_pkg::STUFF_BYTE;
                n_rep      = i_head.stuff_cnt;
                n_last     = 1'b1;
            end
            default: begin
                // data byte
                n_out_byte = i_head.data;
                n_last     = !i_head.stuff;
                nxt_step   = i_head.stuff ? STEP_STUFF : STEP_START;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= STEP_START;
            r_out_valid <= 1'b0;
        end else begin
            if (advance) begin
                r_step      <= n_last ? STEP_START : nxt_step;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_byte <= n_out_byte;
            r_rep      <= n_rep;
            r_last     <= n_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_repeat_count = r_rep;
    assign o_last_of_item = r_last;

endmodule
